// ===== sv/rti_pkg.sv =====
// ---------------------------------------------------------------------------
// rti_pkg
// Shared codes, widths and state types of the ray/triangle intersect block.
// ---------------------------------------------------------------------------
package rti_pkg;

  localparam int VREG_BITS    = 63;
  localparam int COLOR_BITS   = 24;
  localparam int NORM_BITS    = 16;
  localparam int NORM_SHIFT   = 14;
  localparam int NORM_KEEP    = 30;
  localparam int ROOT_BITS    = 64;
  localparam int LEN_BITS     = 32;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VERTEX0,
    CFG_VERTEX1,
    CFG_VERTEX2,
    CFG_COLOR
  } cfg_idx_t;

  typedef enum logic [3:0] {
    NRM_IDLE,
    NRM_MUL,
    NRM_SUB,
    NRM_ABS,
    NRM_SHIFT,
    NRM_SQUARE,
    NRM_SUM,
    NRM_ROOT,
    NRM_PREP,
    NRM_DIV,
    NRM_SIGN
  } nrm_state_t;

endpackage

// ===== sv/ray_triangle_intersect_top.sv =====
// ---------------------------------------------------------------------------
// ray_triangle_intersect_top
// Pipelined ray against one configured triangle, Cramer's rule in exact
// fixed point, with a sequential face normal engine behind the config port.
// ---------------------------------------------------------------------------
// One ray word is taken per cycle while busy is low, and its result word
// appears on the out_ ports for one cycle, after the bit-per-stage distance
// divider. The receiver cannot stall and none is needed. A write to a vertex
// register starts the face normal engine, which holds busy high until its
// bit-serial square root and divider are done.
module ray_triangle_intersect_top
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic signed [COORD_BITS-1:0]  in_origin_x,
  input  logic signed [COORD_BITS-1:0]  in_origin_y,
  input  logic signed [COORD_BITS-1:0]  in_origin_z,
  input  logic signed [COORD_BITS-1:0]  in_dir_x,
  input  logic signed [COORD_BITS-1:0]  in_dir_y,
  input  logic signed [COORD_BITS-1:0]  in_dir_z,
  input  logic signed [COORD_BITS-1:0]  in_t_min,
  input  logic signed [COORD_BITS-1:0]  in_t_max,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [COORD_BITS-1:0]  out_distance,
  output logic signed [NORM_BITS-1:0]   out_normal_x,
  output logic signed [NORM_BITS-1:0]   out_normal_y,
  output logic signed [NORM_BITS-1:0]   out_normal_z,
  output logic [COLOR_BITS-1:0]         out_hit_color,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx,
  input  logic [VREG_BITS-1:0]          cfg_data
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int AW  = PW + 1;
  localparam int H   = C + 2;
  localparam int LW  = DW + H + 1;
  localparam int TW  = AW + DW;
  localparam int NW  = TW + 2;
  localparam int RW  = NW + F;
  localparam int XW  = RW + C;
  localparam int QB  = C - 1;
  localparam int NV  = QB + 10;
  localparam int LATENCY = NV + 1;
  localparam int EXT = (3 * C > VREG_BITS) ? 3 * C : VREG_BITS;
  localparam int MW  = (AW > NORM_KEEP + 1) ? AW : NORM_KEEP + 1;
  localparam int DSW = LEN_BITS + NORM_SHIFT;
  localparam int DRW = NORM_KEEP + NORM_SHIFT;
  localparam int QN  = NORM_SHIFT + 1;

  typedef struct packed {
    logic         shadow;
    logic [C-1:0] tmin;
    logic [C-1:0] tmax;
  } ctl_t;

  typedef struct packed {
    logic cond;
    logic tneg;
    logic sat;
  } flg_t;

  // configuration
  logic [VREG_BITS-1:0]  vtx0_r, vtx1_r, vtx2_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  vtx_wr;

  assign vtx_wr = cfg_we && (cfg_idx != CFG_COLOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx0_r  <= '0;
      vtx1_r  <= '0;
      vtx2_r  <= '0;
      color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_VERTEX0: vtx0_r  <= cfg_data;
        CFG_VERTEX1: vtx1_r  <= cfg_data;
        CFG_VERTEX2: vtx2_r  <= cfg_data;
        CFG_COLOR:   color_r <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [EXT-1:0]        v0e, v1e, v2e;
  logic signed [C-1:0]   p0 [3];
  logic signed [C-1:0]   p1 [3];
  logic signed [C-1:0]   p2 [3];
  logic signed [DW-1:0]  a1 [3];
  logic signed [DW-1:0]  a2 [3];

  assign v0e = EXT'(vtx0_r);
  assign v1e = EXT'(vtx1_r);
  assign v2e = EXT'(vtx2_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = signed'(v0e[k*C +: C]);
      p1[k] = signed'(v1e[k*C +: C]);
      p2[k] = signed'(v2e[k*C +: C]);
      a1[k] = DW'(p0[k]) - DW'(p1[k]);
      a2[k] = DW'(p0[k]) - DW'(p2[k]);
    end
  end

  // valid and control travel down a shift line, one tap per stage
  logic       acc;
  logic [NV-1:0] vld_r;
  ctl_t       ctl_r [NV];

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NV-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= '{shadow: in_action, tmin: in_t_min, tmax: in_t_max};
    for (int s = 1; s < NV; s++) begin
      ctl_r[s] <= ctl_r[s-1];
    end
  end

  // stage 1: right-hand side and direction
  logic signed [DW-1:0] b1_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [C-1:0]  org [3];
  logic signed [C-1:0]  dir [3];

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      b1_r[k] <= DW'(p0[k]) - DW'(org[k]);
      d1_r[k] <= DW'(dir[k]);
    end
  end

  // stage 2: cofactor products
  logic signed [PW-1:0] pr_r [12];
  logic signed [DW-1:0] b2_r [3];
  logic signed [DW-1:0] d2_r [3];

  always_ff @(posedge clk) begin
    pr_r[0]  <= a2[1] * d1_r[2];
    pr_r[1]  <= d1_r[1] * a2[2];
    pr_r[2]  <= d1_r[0] * a2[2];
    pr_r[3]  <= a2[0] * d1_r[2];
    pr_r[4]  <= a2[0] * d1_r[1];
    pr_r[5]  <= d1_r[0] * a2[1];
    pr_r[6]  <= a1[1] * b1_r[2];
    pr_r[7]  <= b1_r[1] * a1[2];
    pr_r[8]  <= a1[2] * b1_r[0];
    pr_r[9]  <= a1[0] * b1_r[2];
    pr_r[10] <= a1[0] * b1_r[1];
    pr_r[11] <= a1[1] * b1_r[0];
    b2_r     <= b1_r;
    d2_r     <= d1_r;
  end

  // stage 3: cofactors
  logic signed [AW-1:0] adj_r [3];
  logic signed [AW-1:0] bd_r  [3];
  logic signed [DW-1:0] b3_r  [3];
  logic signed [DW-1:0] d3_r  [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      adj_r[k] <= AW'(pr_r[2*k])     - AW'(pr_r[2*k+1]);
      bd_r[k]  <= AW'(pr_r[6+2*k])   - AW'(pr_r[7+2*k]);
    end
    b3_r <= b2_r;
    d3_r <= d2_r;
  end

  // stage 4: split partial products of the four dot products
  logic signed [DW-1:0] mx [12];
  logic signed [AW-1:0] my [12];
  logic signed [LW-1:0] ppl_r [12];
  logic signed [PW-1:0] pph_r [12];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mx[k]   = a1[k];
      my[k]   = adj_r[k];
      mx[3+k] = b3_r[k];
      my[3+k] = adj_r[k];
      mx[6+k] = d3_r[k];
      my[6+k] = bd_r[k];
      mx[9+k] = a2[k];
      my[9+k] = bd_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 12; i++) begin
      ppl_r[i] <= mx[i] * $signed({1'b0, my[i][H-1:0]});
      pph_r[i] <= mx[i] * $signed(my[i][AW-1:H]);
    end
  end

  // stage 5: whole terms
  logic signed [TW-1:0] tm_r [12];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 12; i++) begin
      tm_r[i] <= (TW'(pph_r[i]) <<< H) + TW'(ppl_r[i]);
    end
  end

  // stage 6: determinant and numerators
  logic signed [NW-1:0] det_r, nb_r, ng_r, nt_r;

  always_ff @(posedge clk) begin
    det_r <= NW'(tm_r[0]) + NW'(tm_r[1]) + NW'(tm_r[2]);
    nb_r  <= NW'(tm_r[3]) + NW'(tm_r[4]) + NW'(tm_r[5]);
    ng_r  <= NW'(tm_r[6]) + NW'(tm_r[7]) + NW'(tm_r[8]);
    nt_r  <= -(NW'(tm_r[9]) + NW'(tm_r[10]) + NW'(tm_r[11]));
  end

  // stage 7: make the determinant non-negative, flipping the numerators with it
  logic signed [NW-1:0] detn_r, nbn_r, ngn_r, ntn_r;
  logic                 detz_r;

  always_ff @(posedge clk) begin
    detz_r <= (det_r == '0);
    if (det_r[NW-1]) begin
      detn_r <= -det_r;
      nbn_r  <= -nb_r;
      ngn_r  <= -ng_r;
      ntn_r  <= -nt_r;
    end else begin
      detn_r <= det_r;
      nbn_r  <= nb_r;
      ngn_r  <= ng_r;
      ntn_r  <= nt_r;
    end
  end

  // stage 8: inside test, numerator magnitude
  logic signed [NW:0]   bgsum;
  logic [NW-1:0]        absn;
  logic                 cond8_r, tneg8_r;
  logic [RW-1:0]        m8_r;
  logic [NW-1:0]        dv8_r;

  assign bgsum = (NW+1)'(nbn_r) + (NW+1)'(ngn_r);
  assign absn  = ntn_r[NW-1] ? unsigned'(-ntn_r) : unsigned'(ntn_r);

  always_ff @(posedge clk) begin
    cond8_r <= !detz_r && (nbn_r > 0) && (ngn_r > 0) && (bgsum < (NW+1)'(detn_r));
    tneg8_r <= ntn_r[NW-1];
    m8_r    <= {absn, {F{1'b0}}};
    dv8_r   <= unsigned'(detn_r);
  end

  // stage 9: range check, then one quotient bit per stage
  logic [RW-1:0] rem_r [QB+1];
  logic [NW-1:0] dq_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  flg_t          fl_r  [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= m8_r;
    dq_r[0]  <= dv8_r;
    q_r[0]   <= '0;
    fl_r[0]  <= '{cond: cond8_r, tneg: tneg8_r,
                  sat: (XW'(m8_r) >= (XW'(dv8_r) << (C - 1)))};
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [XW-1:0] sh;
    logic          ge;
    logic [QB-1:0] qn;

    assign sh = XW'(dq_r[j]) << K;
    assign ge = XW'(rem_r[j]) >= sh;

    always_comb begin
      qn    = q_r[j];
      qn[K] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? RW'(XW'(rem_r[j]) - sh) : rem_r[j];
      dq_r[j+1]  <= dq_r[j];
      q_r[j+1]   <= qn;
      fl_r[j+1]  <= fl_r[j];
    end
  end

  // distance with saturation
  logic signed [C-1:0] tq_r;
  logic                hc_r;
  logic signed [C-1:0] qs;

  assign qs = $signed({1'b0, q_r[QB]});

  always_ff @(posedge clk) begin
    hc_r <= fl_r[QB].cond;
    if (fl_r[QB].sat) begin
      tq_r <= fl_r[QB].tneg ? $signed({1'b1, {(C-1){1'b0}}})
                            : $signed({1'b0, {(C-1){1'b1}}});
    end else begin
      tq_r <= fl_r[QB].tneg ? -qs : qs;
    end
  end

  // face normal engine
  nrm_state_t              nrm_state_r, nrm_state_nxt;
  logic signed [PW-1:0]    ep_r  [6];
  logic signed [AW-1:0]    c_r   [3];
  logic [MW-1:0]           mag_r [3];
  logic                    neg_r [3];
  logic [2*NORM_KEEP-1:0]  sq_r  [3];
  logic [ROOT_BITS-1:0]    rx_r, rr_r, rb_r, rt;
  logic [LEN_BITS-1:0]     len_r;
  logic [DSW-1:0]          ds_r;
  logic [DRW-1:0]          drem_r [3];
  logic [QN-1:0]           nq_r   [3];
  logic [3:0]              dcnt_r;
  logic signed [NORM_BITS-1:0] nrm_r [3];
  logic                    big;

  assign big = |mag_r[0][MW-1:NORM_KEEP] || |mag_r[1][MW-1:NORM_KEEP]
            || |mag_r[2][MW-1:NORM_KEEP];
  assign rt  = rr_r + rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_state_r <= NRM_IDLE;
    end else begin
      nrm_state_r <= nrm_state_nxt;
    end
  end

  always_comb begin
    nrm_state_nxt = nrm_state_r;
    unique case (nrm_state_r)
      NRM_IDLE:   nrm_state_nxt = NRM_IDLE;
      NRM_MUL:    nrm_state_nxt = NRM_SUB;
      NRM_SUB:    nrm_state_nxt = NRM_ABS;
      NRM_ABS:    nrm_state_nxt = NRM_SHIFT;
      NRM_SHIFT:  if (!big) nrm_state_nxt = NRM_SQUARE;
      NRM_SQUARE: nrm_state_nxt = NRM_SUM;
      NRM_SUM:    nrm_state_nxt = NRM_ROOT;
      NRM_ROOT:   if (rb_r[0]) nrm_state_nxt = NRM_PREP;
      NRM_PREP:   nrm_state_nxt = NRM_DIV;
      NRM_DIV:    if (dcnt_r == '0) nrm_state_nxt = NRM_SIGN;
      NRM_SIGN:   nrm_state_nxt = NRM_IDLE;
      default:    nrm_state_nxt = NRM_IDLE;
    endcase
    if (vtx_wr) nrm_state_nxt = NRM_MUL;
  end

  assign busy = (nrm_state_r != NRM_IDLE);

  always_ff @(posedge clk) begin
    unique case (nrm_state_r)
      NRM_MUL: begin
        ep_r[0] <= a1[1] * a2[2];
        ep_r[1] <= a1[2] * a2[1];
        ep_r[2] <= a1[2] * a2[0];
        ep_r[3] <= a1[0] * a2[2];
        ep_r[4] <= a1[0] * a2[1];
        ep_r[5] <= a1[1] * a2[0];
      end
      NRM_SUB: begin
        for (int k = 0; k < 3; k++) c_r[k] <= AW'(ep_r[2*k]) - AW'(ep_r[2*k+1]);
      end
      NRM_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= c_r[k][AW-1];
          mag_r[k] <= MW'(c_r[k][AW-1] ? unsigned'(-c_r[k]) : unsigned'(c_r[k]));
        end
      end
      NRM_SHIFT: begin
        if (big) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end
      end
      NRM_SQUARE: begin
        for (int k = 0; k < 3; k++) begin
          sq_r[k] <= mag_r[k][NORM_KEEP-1:0] * mag_r[k][NORM_KEEP-1:0];
        end
      end
      NRM_SUM: begin
        rx_r <= ROOT_BITS'(sq_r[0]) + ROOT_BITS'(sq_r[1]) + ROOT_BITS'(sq_r[2]);
        rr_r <= '0;
        rb_r <= ROOT_BITS'(1) << (ROOT_BITS - 2);
      end
      NRM_ROOT: begin
        if (rx_r >= rt) begin
          rx_r <= rx_r - rt;
          rr_r <= (rr_r >> 1) + rb_r;
        end else begin
          rr_r <= rr_r >> 1;
        end
        rb_r <= rb_r >> 2;
      end
      NRM_PREP: begin
        len_r  <= rr_r[LEN_BITS-1:0];
        ds_r   <= {rr_r[LEN_BITS-1:0], {NORM_SHIFT{1'b0}}};
        dcnt_r <= 4'(NORM_SHIFT);
        for (int k = 0; k < 3; k++) begin
          drem_r[k] <= {mag_r[k][NORM_KEEP-1:0], {NORM_SHIFT{1'b0}}};
          nq_r[k]   <= '0;
        end
      end
      NRM_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (DSW'(drem_r[k]) >= ds_r) begin
            drem_r[k] <= DRW'(DSW'(drem_r[k]) - ds_r);
            nq_r[k]   <= {nq_r[k][QN-2:0], 1'b1};
          end else begin
            nq_r[k]   <= {nq_r[k][QN-2:0], 1'b0};
          end
        end
        ds_r   <= ds_r >> 1;
        dcnt_r <= dcnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) nrm_r[k] <= '0;
    end else if (nrm_state_r == NRM_SIGN) begin
      for (int k = 0; k < 3; k++) begin
        if (len_r == '0) nrm_r[k] <= '0;
        else if (neg_r[k]) nrm_r[k] <= -$signed({1'b0, nq_r[k]});
        else nrm_r[k] <= $signed({1'b0, nq_r[k]});
      end
    end
  end

  // output register
  logic                        out_valid_r, out_hit_r;
  logic signed [C-1:0]         out_distance_r;
  logic signed [NORM_BITS-1:0] out_nx_r, out_ny_r, out_nz_r;
  logic [COLOR_BITS-1:0]       out_color_r;
  logic                        hit, full;

  assign hit  = hc_r && (tq_r >= $signed(ctl_r[NV-1].tmin))
                     && (tq_r <= $signed(ctl_r[NV-1].tmax));
  assign full = hit && !ctl_r[NV-1].shadow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r      <= hit;
    out_distance_r <= full ? tq_r : '0;
    out_nx_r       <= full ? nrm_r[0] : '0;
    out_ny_r       <= full ? nrm_r[1] : '0;
    out_nz_r       <= full ? nrm_r[2] : '0;
    out_color_r    <= full ? color_r : '0;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_distance  = out_distance_r;
  assign out_normal_x  = out_nx_r;
  assign out_normal_y  = out_ny_r;
  assign out_normal_z  = out_nz_r;
  assign out_hit_color = out_color_r;

endmodule

// ===== sv/rti_checker.sv =====
// ---------------------------------------------------------------------------
// rti_checker
// Port-level checks of the ray/triangle intersect block, bound to the top.
// ---------------------------------------------------------------------------
module rti_checker
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int LAT        = 31
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic signed [COORD_BITS-1:0]  out_distance,
  input logic signed [NORM_BITS-1:0]   out_normal_x,
  input logic signed [NORM_BITS-1:0]   out_normal_y,
  input logic signed [NORM_BITS-1:0]   out_normal_z,
  input logic [COLOR_BITS-1:0]         out_hit_color,
  input logic                          cfg_we,
  input logic [CFG_IDX_BITS-1:0]       cfg_idx
);

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted word");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_distance == '0 && out_normal_x == '0
      && out_normal_y == '0 && out_normal_z == '0 && out_hit_color == '0))
    else $error("miss with nonzero fields");

  a_shadow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |-> ##LAT (out_distance == '0
      && out_hit_color == '0 && out_normal_x == '0))
    else $error("shadow word with record fields");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(cfg_we) && ($past(cfg_idx) != CFG_COLOR)))
    else $error("busy without vertex write");

endmodule

bind ray_triangle_intersect_top rti_checker #(
  .COORD_BITS (COORD_BITS),
  .LAT        (LATENCY)
) u_rti_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_hit       (out_hit),
  .out_distance  (out_distance),
  .out_normal_x  (out_normal_x),
  .out_normal_y  (out_normal_y),
  .out_normal_z  (out_normal_z),
  .out_hit_color (out_hit_color),
  .cfg_we        (cfg_we),
  .cfg_idx       (cfg_idx)
);
